// ----- rtl/csl_pkg.sv -----
`timescale 1ns / 1ps

package csl_pkg;

  // Token kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_COMMA  = 4'd0,
    KIND_PLUS   = 4'd1,
    KIND_MINUS  = 4'd2,
    KIND_STAR   = 4'd3,
    KIND_LBRACK = 4'd4,
    KIND_RBRACK = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_NUMBER = 4'd8,
    KIND_WORD   = 4'd9,
    KIND_ERROR  = 4'd10,
    KIND_END    = 4'd11
  } kind_e;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Most results one input item can cause.
  localparam int unsigned MaxResults = 3;

  // One result item.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] chr;
    logic       tok_last;
    logic       run_last;
  } tok_t;

  // Number or word character held until the next character arrives.
  typedef struct packed {
    logic       valid;
    logic [7:0] chr;
    logic       is_word;
  } pend_t;

  // Everything the classifier hands back for one item.
  typedef struct packed {
    tok_t [MaxResults-1:0] toks;
    logic [1:0]            count;
    pend_t                 next;
  } cls_t;

  typedef struct packed {
    logic  hit;
    kind_e kind;
  } mark_t;

  function automatic mark_t mark_lookup(input logic [7:0] c);
    mark_t m;
    m.hit  = 1'b1;
    m.kind = KIND_ERROR;
    unique case (c)
      CH_COMMA:  m.kind = KIND_COMMA;
      CH_PLUS:   m.kind = KIND_PLUS;
      CH_MINUS:  m.kind = KIND_MINUS;
      CH_STAR:   m.kind = KIND_STAR;
      CH_LBRACK: m.kind = KIND_LBRACK;
      CH_RBRACK: m.kind = KIND_RBRACK;
      CH_LPAREN: m.kind = KIND_LPAREN;
      CH_RPAREN: m.kind = KIND_RPAREN;
      default:   m.hit  = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/csl_char_if.sv -----
`timescale 1ns / 1ps

interface csl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

// ----- rtl/csl_tok_if.sv -----
`timescale 1ns / 1ps

interface csl_tok_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] token_char;
  logic       token_last;
  logic       run_last;

  modport source (output valid, output token_kind, output token_char, output token_last,
                  output run_last, input ready);
  modport sink   (input valid, input token_kind, input token_char, input token_last,
                  input run_last, output ready);
endinterface

// ----- rtl/csl_classify.sv -----
`timescale 1ns / 1ps

// Works out the results of one character against the held character and
// the held character that follows it.
module csl_classify (
  input  logic [7:0]     chr_i,
  input  logic           eoi_i,
  input  csl_pkg::pend_t pend_i,
  output csl_pkg::cls_t  cls_o
);

  logic           is_digit;
  logic           is_letter;
  logic           word_ch;
  logic           num_ch;
  logic           continues;
  logic           c_tok;
  logic           c_word;
  logic [1:0]     n;
  csl_pkg::mark_t mark;

  assign is_digit  = (chr_i >= 8'h30) && (chr_i <= 8'h39);
  assign is_letter = ((chr_i >= 8'h61) && (chr_i <= 8'h7A)) ||
                     ((chr_i >= 8'h41) && (chr_i <= 8'h5A));
  assign word_ch   = is_letter || is_digit || (chr_i == csl_pkg::CH_UNDER);
  assign num_ch    = is_digit || (chr_i == csl_pkg::CH_X);
  assign continues = pend_i.valid && (pend_i.is_word ? word_ch : num_ch);
  assign mark      = csl_pkg::mark_lookup(chr_i);

  always_comb begin
    cls_o = '0;
    n     = 2'd0;

    // The held character goes out first.
    if (pend_i.valid) begin
      cls_o.toks[n].kind     = pend_i.is_word ? csl_pkg::KIND_WORD : csl_pkg::KIND_NUMBER;
      cls_o.toks[n].chr      = pend_i.chr;
      cls_o.toks[n].tok_last = !continues;
      n = n + 2'd1;
    end

    c_tok  = 1'b0;
    c_word = 1'b0;
    if (continues) begin
      c_tok  = 1'b1;
      c_word = pend_i.is_word;
    end else if (is_digit) begin
      c_tok  = 1'b1;
    end else if (is_letter || (chr_i == csl_pkg::CH_UNDER)) begin
      c_tok  = 1'b1;
      c_word = 1'b1;
    end

    if (c_tok) begin
      if (eoi_i) begin
        cls_o.toks[n].kind     = c_word ? csl_pkg::KIND_WORD : csl_pkg::KIND_NUMBER;
        cls_o.toks[n].chr      = chr_i;
        cls_o.toks[n].tok_last = 1'b1;
        n = n + 2'd1;
      end else begin
        cls_o.next.valid   = 1'b1;
        cls_o.next.chr     = chr_i;
        cls_o.next.is_word = c_word;
      end
    end else if (mark.hit) begin
      cls_o.toks[n].kind     = mark.kind;
      cls_o.toks[n].chr      = chr_i;
      cls_o.toks[n].tok_last = 1'b1;
      n = n + 2'd1;
    end else if ((chr_i != csl_pkg::CH_SPACE) && (chr_i != csl_pkg::CH_TAB)) begin
      cls_o.toks[n].kind     = csl_pkg::KIND_ERROR;
      cls_o.toks[n].chr      = chr_i;
      cls_o.toks[n].tok_last = 1'b1;
      n = n + 2'd1;
    end

    if (eoi_i) begin
      cls_o.toks[n].kind     = csl_pkg::KIND_END;
      cls_o.toks[n].chr      = 8'h00;
      cls_o.toks[n].tok_last = 1'b1;
      n = n + 2'd1;
    end

    if (n != 2'd0) begin
      cls_o.toks[n - 2'd1].run_last = 1'b1;
    end
    cls_o.count = n;
  end

endmodule

// ----- rtl/char_stream_lexer.sv -----
`timescale 1ns / 1ps

// Character stream lexer. One character enters per input item and comes out
// tagged with its token kind, one item late for numbers and words, since the
// next character decides whether the token ends. Spaces and tabs are dropped,
// the eight marks , + - * [ ] ( ) and any unknown byte each make a one-
// character token, and the item flagged end_of_input also flushes the held
// character, appends an end marker and returns the lexer to its start state.
// Each input item causes zero to three result items; run_last flags the last
// result of each item. Timing: an item is registered on entry, classified from
// the input register and its results loaded into a three-entry result buffer
// once that buffer is empty or its last result is leaving; the buffer drains
// one result per cycle while the output is ready. A new item is taken every
// cycle while results keep up; the output port's one-result-per-cycle drain
// sets the sustained rate. Results pass the input register, then the buffer.
module char_stream_lexer (
  input  logic       clk_i,
  input  logic       rst_ni,
  csl_char_if.sink   in_i,
  csl_tok_if.source  out_o
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_chr_q;
  logic       in_eoi_q;

  // Held number or word character.
  csl_pkg::pend_t pend_q, pend_d;

  // Result buffer: results of one item, drained from the head.
  csl_pkg::tok_t buf_q [csl_pkg::MaxResults];
  logic [1:0]    head_q, head_d;
  logic [1:0]    cnt_q, cnt_d;

  csl_pkg::cls_t cls;
  logic          pop;
  logic          load;

  csl_classify u_classify (
    .chr_i  (in_chr_q),
    .eoi_i  (in_eoi_q),
    .pend_i (pend_q),
    .cls_o  (cls)
  );

  assign pop  = out_o.valid && out_o.ready;
  // The buffer takes the next item's results once it is empty or its last
  // result leaves in this cycle.
  assign load = in_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));

  assign in_i.ready = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_chr_q <= in_i.char_in;
      in_eoi_q <= in_i.end_of_input;
    end
  end

  always_comb begin
    pend_d = pend_q;
    head_d = head_q;
    cnt_d  = cnt_q;
    if (load) begin
      pend_d = cls.next;
      head_d = 2'd0;
      cnt_d  = cls.count;
    end else if (pop) begin
      head_d = head_q + 2'd1;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      head_q <= 2'd0;
      cnt_q  <= 2'd0;
    end else begin
      pend_q <= pend_d;
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < csl_pkg::MaxResults; i++) begin
        buf_q[i] <= cls.toks[i];
      end
    end
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.token_kind = buf_q[head_q].kind;
  assign out_o.token_char = buf_q[head_q].chr;
  assign out_o.token_last = buf_q[head_q].tok_last;
  assign out_o.run_last   = buf_q[head_q].run_last;

endmodule
